// ===== rtl/chord_note_expander_top_macros.svh =====
// Assertion macros used by the chord note expander controller.
`ifndef CHORD_NOTE_EXPANDER_TOP_MACROS_SVH
`define CHORD_NOTE_EXPANDER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CNE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define CNE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cne_pkg.sv =====
// Shared types and constants of the chord note expander.
`timescale 1ns / 1ps
package cne_pkg;

  localparam int NumPresetsDef = 8;
  localparam int MaxTonesDef   = 4;

  localparam int PitchClasses = 12;
  localparam int NoteMax      = 127;
  localparam int RoundBias    = 50;
  localparam int PercentFull  = 100;
  localparam int ScaleMax     = 200;
  localparam int IntervalLim  = 48;
  localparam int ShiftLim     = 24;
  localparam int DefaultCount = 3;
  localparam int DefaultTones = 4;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 36;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAP    = 1'b1;

  // request commands; code 3 is unused
  typedef enum logic [1:0] {
    CMD_TONE = 2'd0,
    CMD_HEAD = 2'd1,
    CMD_PLAY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic start;      // capture root/velocity, pitch class
    logic wr_tone;    // write one tone slot
    logic wr_head;    // write a preset header
    logic sel;        // resolve preset index
    logic load;       // fetch preset rows
    logic tone_step;  // evaluate one tone, dedup
    logic mul;        // velocity times scale
    logic emit;       // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_tone;
    logic last_emit;
    logic out_free;
  } dp_sts_t;

  function automatic logic [6:0] def_interval(input int t);
    logic [6:0] v;
    unique case (t)
      0:       v = 7'd0;
      1:       v = 7'd4;
      2:       v = 7'd7;
      3:       v = 7'd12;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] def_scale(input int t);
    logic [7:0] v;
    unique case (t)
      0:       v = 8'd100;
      1:       v = 8'd95;
      2:       v = 8'd90;
      3:       v = 8'd80;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/chord_note_expander_top.sv =====
// Top level of the chord note expander: controller plus datapath.
//
//   channel   direction  handshake                 contents
//   cfg       in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//   request   in         in_valid_i / in_stall_o   command and tone/preset/root fields
//   result    out        out_valid_o / out_stall_i note, velocity, preset, last flag
//
// A table write request is done in its accept step. A play request steps through
// accept, preset select, row fetch, a dedup step per tone, then a multiply and an
// output load per kept note, all through the one shared scaler.
// A stalled result holds the sequencer in its emit step; the last result of a chord
// may wait in the output register while the next request is accepted.
// Reset (rst_ni low, asynchronous) restores the default presets and configuration.
`timescale 1ns / 1ps
module chord_note_expander_top
  import cne_pkg::*;
#(
  parameter int NUM_PRESETS = NumPresetsDef,  // 1..16
  parameter int MAX_TONES   = MaxTonesDef     // 1..8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [2:0]          preset_index_i,
  input  logic [1:0]          tone_slot_i,
  input  logic signed [6:0]   tone_interval_i,
  input  logic [7:0]          tone_scale_i,
  input  logic [2:0]          tone_count_i,
  input  logic signed [5:0]   shift_i,
  input  logic [6:0]          root_note_i,
  input  logic [6:0]          velocity_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [6:0]          note_o,
  output logic [6:0]          note_velocity_o,
  output logic [2:0]          chosen_preset_o,
  output logic                last_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: decodes the request command and steps through a chord
  cne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // tables, tone dedup, velocity scaler and output register
  cne_dpath #(
    .NUM_PRESETS (NUM_PRESETS),
    .MAX_TONES   (MAX_TONES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .preset_index_i  (preset_index_i),
    .tone_slot_i     (tone_slot_i),
    .tone_interval_i (tone_interval_i),
    .tone_scale_i    (tone_scale_i),
    .tone_count_i    (tone_count_i),
    .shift_i         (shift_i),
    .root_note_i     (root_note_i),
    .velocity_i      (velocity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .note_o          (note_o),
    .note_velocity_o (note_velocity_o),
    .chosen_preset_o (chosen_preset_o),
    .last_o          (last_o)
  );

endmodule

// ===== rtl/cne_ctrl.sv =====
// Sequencing state machine of the chord note expander.
`timescale 1ns / 1ps
`include "chord_note_expander_top_macros.svh"
module cne_ctrl
  import cne_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_TONE = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_TONE: cmd_o.wr_tone = 1'b1;
            CMD_HEAD: cmd_o.wr_head = 1'b1;
            CMD_PLAY: begin
              cmd_o.start = 1'b1;
              state_d     = S_SEL;
            end
            default: ;
          endcase
        end
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_TONE;
      end
      S_TONE: begin
        cmd_o.tone_step = 1'b1;
        if (sts_i.last_tone) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last_emit ? S_IDLE : S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `CNE_ASSERT_NXT(a_play_starts, clk_i, rst_ni,
                  accept && (command_i == CMD_PLAY), state_q == S_SEL, "play not started")
  `CNE_ASSERT_NXT(a_emit_holds, clk_i, rst_ni,
                  (state_q == S_EMIT) && !sts_i.out_free, state_q == S_EMIT, "emit lost")
  `CNE_ASSERT_NXT(a_chord_ends, clk_i, rst_ni,
                  (state_q == S_EMIT) && sts_i.out_free && sts_i.last_emit,
                  state_q == S_IDLE, "chord did not end")

endmodule

// ===== rtl/cne_dpath.sv =====
// Datapath of the chord note expander: tables, dedup, velocity scaling, output register.
`timescale 1ns / 1ps
module cne_dpath
  import cne_pkg::*;
#(
  parameter int NUM_PRESETS = NumPresetsDef,
  parameter int MAX_TONES   = MaxTonesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [2:0]          preset_index_i,
  input  logic [1:0]          tone_slot_i,
  input  logic signed [6:0]   tone_interval_i,
  input  logic [7:0]          tone_scale_i,
  input  logic [2:0]          tone_count_i,
  input  logic signed [5:0]   shift_i,
  input  logic [6:0]          root_note_i,
  input  logic [6:0]          velocity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [6:0]          note_o,
  output logic [6:0]          note_velocity_o,
  output logic [2:0]          chosen_preset_o,
  output logic                last_o
);

  localparam int PW     = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;
  localparam int TW     = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int KW     = $clog2(MAX_TONES + 1);
  localparam int CntMax = (MAX_TONES > 7) ? 7 : MAX_TONES;
  // x / 100 == (x * 5243) >> 19 for every x below 2^15
  localparam int RecipMul   = 5243;
  localparam int RecipShift = 19;

  // preset tables, one row per preset
  logic [MAX_TONES*7-1:0] iv_row_q [NUM_PRESETS];
  logic [MAX_TONES*8-1:0] sc_row_q [NUM_PRESETS];
  logic [2:0]             cnt_q    [NUM_PRESETS];
  logic signed [5:0]      tr_q     [NUM_PRESETS];

  logic [3:0]  active_q;
  logic [35:0] map_q;

  // per-chord working registers
  logic [6:0]             root_q, vel_q;
  logic [3:0]             pc_q;
  logic [2:0]             pi_q;
  logic [MAX_TONES*7-1:0] iv_cur_q;
  logic [MAX_TONES*8-1:0] sc_cur_q;
  logic [2:0]             n_q;
  logic signed [5:0]      tr_cur_q;
  logic [TW-1:0]          tone_q, em_q;
  logic [KW-1:0]          kept_q;
  logic [6:0]             kept_note_q  [MAX_TONES];
  logic [7:0]             kept_scale_q [MAX_TONES];
  logic [14:0]            prod_q;

  logic       out_valid_q, out_last_q;
  logic [6:0] out_note_q, out_vel_q;
  logic [2:0] out_pi_q;

  // write-side clamps
  logic signed [6:0] iv_wr;
  logic [7:0]        sc_wr;
  logic [2:0]        cnt_wr;
  logic signed [5:0] tr_wr;

  always_comb begin
    if (tone_interval_i < -7'sd48)     iv_wr = -7'sd48;
    else if (tone_interval_i > 7'sd48) iv_wr = 7'sd48;
    else                               iv_wr = tone_interval_i;
    sc_wr = (tone_scale_i > 8'(ScaleMax)) ? 8'(ScaleMax) : tone_scale_i;
    if (tone_count_i == 3'd0)                   cnt_wr = 3'd1;
    else if (int'(tone_count_i) > CntMax)       cnt_wr = 3'(CntMax);
    else                                        cnt_wr = tone_count_i;
    if (shift_i < -6'sd24)     tr_wr = -6'sd24;
    else if (shift_i > 6'sd24) tr_wr = 6'sd24;
    else                       tr_wr = shift_i;
  end

  // root mod 12 by restoring subtraction of 96, 48, 24, 12
  function automatic logic [3:0] pitch_class(input logic [6:0] r);
    logic [6:0] x;
    x = r;
    for (int k = 3; k >= 0; k--) begin
      if (x >= 7'(PitchClasses << k)) x = x - 7'(PitchClasses << k);
    end
    return x[3:0];
  endfunction

  // preset selection
  logic [4:0] act_eff;
  logic [2:0] pi_raw, pi_sel;
  logic [PW-1:0] pi_idx;

  always_comb begin
    if (active_q == 4'd0)                   act_eff = 5'd1;
    else if (int'(active_q) > NUM_PRESETS)  act_eff = 5'(NUM_PRESETS);
    else                                    act_eff = {1'b0, active_q};
    pi_raw = map_q[pc_q*3 +: 3];
    pi_sel = ({2'b00, pi_raw} >= act_eff) ? 3'd0 : pi_raw;
  end

  assign pi_idx = PW'(pi_q);

  // tone evaluation
  logic signed [6:0] iv_t;
  logic [7:0]        sc_t;
  logic signed [8:0] note_sum;
  logic [6:0]        note_cl;
  logic              seen;
  logic [2:0]        n_ld;

  always_comb begin
    iv_t     = iv_cur_q[tone_q*7 +: 7];
    sc_t     = sc_cur_q[tone_q*8 +: 8];
    note_sum = $signed({2'b00, root_q}) + 9'(iv_t) + 9'(tr_cur_q);
    if (note_sum < 9'sd0)              note_cl = 7'd0;
    else if (note_sum > 9'(NoteMax))   note_cl = 7'(NoteMax);
    else                               note_cl = note_sum[6:0];
    seen = 1'b0;
    for (int j = 0; j < MAX_TONES; j++) begin
      if ((j < int'(kept_q)) && (kept_note_q[j] == note_cl)) seen = 1'b1;
    end
    if (cnt_q[pi_idx] == 3'd0)                 n_ld = 3'd1;
    else if (int'(cnt_q[pi_idx]) > CntMax)     n_ld = 3'(CntMax);
    else                                       n_ld = cnt_q[pi_idx];
  end

  // velocity: (vel * scale + 50) / 100, saturated
  logic [14:0] vsum;
  logic [27:0] qprod;
  logic [8:0]  vq;
  logic [6:0]  vsat;

  always_comb begin
    vsum  = prod_q + 15'(RoundBias);
    qprod = 28'(vsum) * 28'(RecipMul);
    vq    = qprod[RecipShift +: 9];
    vsat  = (vq > 9'(NoteMax)) ? 7'(NoteMax) : vq[6:0];
  end

  assign sts_o.last_tone = (int'(tone_q) + 1 == int'(n_q));
  assign sts_o.last_emit = (KW'(em_q) + KW'(1) == kept_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // configuration and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 4'd1;
      map_q    <= '0;
      for (int p = 0; p < NUM_PRESETS; p++) begin
        cnt_q[p] <= 3'(DefaultCount);
        tr_q[p]  <= '0;
        for (int t = 0; t < MAX_TONES; t++) begin
          iv_row_q[p][t*7 +: 7] <= def_interval(t);
          sc_row_q[p][t*8 +: 8] <= def_scale(t);
        end
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ACTIVE: active_q <= cfg_wdata_i[3:0];
          CFG_MAP:    map_q    <= cfg_wdata_i[35:0];
          default: ;
        endcase
      end
      for (int p = 0; p < NUM_PRESETS; p++) begin
        if (int'(preset_index_i) == p) begin
          if (cmd_i.wr_head) begin
            cnt_q[p] <= cnt_wr;
            tr_q[p]  <= tr_wr;
          end
          for (int t = 0; t < MAX_TONES; t++) begin
            if (cmd_i.wr_tone && (int'(tone_slot_i) == t)) begin
              iv_row_q[p][t*7 +: 7] <= iv_wr;
              sc_row_q[p][t*8 +: 8] <= sc_wr;
            end
          end
        end
      end
    end
  end

  // chord working state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_q <= '0;
      em_q   <= '0;
      kept_q <= '0;
    end else begin
      if (cmd_i.load) begin
        tone_q <= '0;
        em_q   <= '0;
        kept_q <= '0;
      end
      if (cmd_i.tone_step) begin
        tone_q <= tone_q + TW'(1);
        if (!seen) kept_q <= kept_q + KW'(1);
      end
      if (cmd_i.emit) em_q <= em_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      root_q <= root_note_i;
      vel_q  <= velocity_i;
      pc_q   <= pitch_class(root_note_i);
    end
    if (cmd_i.sel) pi_q <= pi_sel;
    if (cmd_i.load) begin
      iv_cur_q <= iv_row_q[pi_idx];
      sc_cur_q <= sc_row_q[pi_idx];
      n_q      <= n_ld;
      tr_cur_q <= tr_q[pi_idx];
    end
    if (cmd_i.tone_step && !seen) begin
      for (int j = 0; j < MAX_TONES; j++) begin
        if (j == int'(kept_q)) begin
          kept_note_q[j]  <= note_cl;
          kept_scale_q[j] <= sc_t;
        end
      end
    end
    if (cmd_i.mul) prod_q <= 15'(vel_q) * 15'(kept_scale_q[em_q]);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_note_q <= kept_note_q[em_q];
      out_vel_q  <= vsat;
      out_pi_q   <= pi_q;
      out_last_q <= sts_o.last_emit;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign note_o          = out_note_q;
  assign note_velocity_o = out_vel_q;
  assign chosen_preset_o = out_pi_q;
  assign last_o          = out_last_q;

endmodule
